@@ hw/rtl/wkst_pkg.sv @@
package wkst_pkg;

    // field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WD_W    = 3;
    // adjusted year: year plus one 400-year cycle
    localparam int YADJ_W  = YEAR_W + 1;
    // year divided by four
    localparam int Q4_W    = YADJ_W - 2;
    // year divided by 100 (at most 167)
    localparam int CENT_W  = 8;
    // weekday sum before reduction modulo 7
    localparam int SUM_W   = 15;

    // month codes
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0]  DAY_LAST    = 5'd31;
    localparam logic [YADJ_W-1:0] CYCLE_YEARS = 15'd400;

    // q4 / 25 as (q4 * 5243) >> 17, exact for every q4 below 2**13
    localparam logic [Q4_W-1:0]   DIV25_MUL   = 13'd5243;
    localparam int                DIV25_SHIFT = 17;

    // month offset plus day 31 for march 31 and october 31
    localparam logic [5:0] MAR31_BIAS = 6'd33;
    localparam logic [5:0] OCT31_BIAS = 6'd37;

    typedef struct packed {
        logic [YEAR_W-1:0]  calendar_year;
        logic [MONTH_W-1:0] month_number;
        logic [DAY_W-1:0]   day_of_month;
    } date_t;

    typedef struct packed {
        logic [WD_W-1:0] weekday;
        logic            summer_time;
        logic            date_invalid;
    } info_t;

    // after year adjust and table lookup
    typedef struct packed {
        logic [YADJ_W-1:0]  y_date;
        logic [YADJ_W-1:0]  y_full;
        logic [2:0]         offset;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               invalid;
    } prep_t;

    // after century division
    typedef struct packed {
        logic [YADJ_W-1:0]  y_date;
        logic [YADJ_W-1:0]  y_full;
        logic [CENT_W-1:0]  c_date;
        logic [CENT_W-1:0]  c_full;
        logic [2:0]         offset;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               invalid;
    } cent_t;

    // weekday sums before reduction
    typedef struct packed {
        logic [SUM_W-1:0]   sum_date;
        logic [SUM_W-1:0]   sum_mar;
        logic [SUM_W-1:0]   sum_oct;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               invalid;
    } sum_t;

    // month offset table, january first
    function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [2:0] r;
        case (m)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd2;
            4'd4:    r = 3'd5;
            4'd5:    r = 3'd0;
            4'd6:    r = 3'd3;
            4'd7:    r = 3'd5;
            4'd8:    r = 3'd1;
            4'd9:    r = 3'd4;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd2;
            4'd12:   r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // modulo 7 by folding octal digits, since 8 is 1 modulo 7
    function automatic logic [WD_W-1:0] mod7(input logic [SUM_W-1:0] a);
        logic [5:0] d;
        logic [3:0] e;
        d = 6'(a[2:0]) + 6'(a[5:3]) + 6'(a[8:6]) + 6'(a[11:9]) + 6'(a[14:12]);
        e = 4'(d[2:0]) + 4'(d[5:3]);
        if (e >= 4'd7)
        begin
            e = e - 4'd7;
        end
        return e[WD_W-1:0];
    endfunction

endpackage

@@ hw/rtl/wkst_prep.sv @@
module wkst_prep (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid,
    input  wkst_pkg::date_t  date,
    output logic             prep_valid,
    output wkst_pkg::prep_t  prep
);

    logic            valid_reg;
    wkst_pkg::prep_t data_reg;
    wkst_pkg::prep_t data_next;

    // year adjust, month table and range check
    always_comb
    begin
        data_next.y_full  = wkst_pkg::YADJ_W'(date.calendar_year) + wkst_pkg::CYCLE_YEARS;
        data_next.y_date  = data_next.y_full
                          - wkst_pkg::YADJ_W'(date.month_number < wkst_pkg::MONTH_MAR);
        data_next.offset  = wkst_pkg::month_offset(date.month_number);
        data_next.month   = date.month_number;
        data_next.day     = date.day_of_month;
        data_next.invalid = (date.month_number < wkst_pkg::MONTH_JAN)
                         || (date.month_number > wkst_pkg::MONTH_DEC)
                         || (date.day_of_month == '0);
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid;
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign prep_valid = valid_reg;
    assign prep       = data_reg;

endmodule

@@ hw/rtl/wkst_century.sv @@
module wkst_century (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid,
    input  wkst_pkg::prep_t  prep,
    output logic             cent_valid,
    output wkst_pkg::cent_t  cent
);

    logic                             valid_reg;
    wkst_pkg::cent_t                  data_reg;
    wkst_pkg::cent_t                  data_next;
    logic [2*wkst_pkg::Q4_W-1:0]      prod_date;
    logic [2*wkst_pkg::Q4_W-1:0]      prod_full;

    // year / 100 as (year / 4) / 25 by reciprocal multiply
    always_comb
    begin
        prod_date = (2*wkst_pkg::Q4_W)'(prep.y_date[wkst_pkg::YADJ_W-1:2])
                  * (2*wkst_pkg::Q4_W)'(wkst_pkg::DIV25_MUL);
        prod_full = (2*wkst_pkg::Q4_W)'(prep.y_full[wkst_pkg::YADJ_W-1:2])
                  * (2*wkst_pkg::Q4_W)'(wkst_pkg::DIV25_MUL);
        data_next.y_date  = prep.y_date;
        data_next.y_full  = prep.y_full;
        data_next.c_date  = prod_date[wkst_pkg::DIV25_SHIFT +: wkst_pkg::CENT_W];
        data_next.c_full  = prod_full[wkst_pkg::DIV25_SHIFT +: wkst_pkg::CENT_W];
        data_next.offset  = prep.offset;
        data_next.month   = prep.month;
        data_next.day     = prep.day;
        data_next.invalid = prep.invalid;
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid;
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign cent_valid = valid_reg;
    assign cent       = data_reg;

endmodule

@@ hw/rtl/wkst_sum.sv @@
module wkst_sum (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid,
    input  wkst_pkg::cent_t  cent,
    output logic             sum_valid,
    output wkst_pkg::sum_t   sum
);

    logic                      valid_reg;
    wkst_pkg::sum_t            data_reg;
    wkst_pkg::sum_t            data_next;
    logic [wkst_pkg::SUM_W:0]  base_date;
    logic [wkst_pkg::SUM_W:0]  base_full;

    // y + y/4 - y/100 + y/400, then month offset and day, or the march 31 and october 31 bias
    always_comb
    begin
        base_date = (wkst_pkg::SUM_W+1)'(cent.y_date)
                  + (wkst_pkg::SUM_W+1)'(cent.y_date[wkst_pkg::YADJ_W-1:2])
                  - (wkst_pkg::SUM_W+1)'(cent.c_date)
                  + (wkst_pkg::SUM_W+1)'(cent.c_date[wkst_pkg::CENT_W-1:2]);
        base_full = (wkst_pkg::SUM_W+1)'(cent.y_full)
                  + (wkst_pkg::SUM_W+1)'(cent.y_full[wkst_pkg::YADJ_W-1:2])
                  - (wkst_pkg::SUM_W+1)'(cent.c_full)
                  + (wkst_pkg::SUM_W+1)'(cent.c_full[wkst_pkg::CENT_W-1:2]);
        data_next.sum_date = wkst_pkg::SUM_W'(base_date + (wkst_pkg::SUM_W+1)'(cent.offset)
                                              + (wkst_pkg::SUM_W+1)'(cent.day));
        data_next.sum_mar  = wkst_pkg::SUM_W'(base_full
                                              + (wkst_pkg::SUM_W+1)'(wkst_pkg::MAR31_BIAS));
        data_next.sum_oct  = wkst_pkg::SUM_W'(base_full
                                              + (wkst_pkg::SUM_W+1)'(wkst_pkg::OCT31_BIAS));
        data_next.month    = cent.month;
        data_next.day      = cent.day;
        data_next.invalid  = cent.invalid;
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid;
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign sum_valid = valid_reg;
    assign sum       = data_reg;

endmodule

@@ hw/rtl/wkst_finish.sv @@
module wkst_finish (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid,
    input  wkst_pkg::sum_t   sum,
    output logic             info_valid,
    output wkst_pkg::info_t  info
);

    logic                          valid_reg;
    wkst_pkg::info_t               data_reg;
    wkst_pkg::info_t               data_next;
    logic [wkst_pkg::WD_W-1:0]     wd_date;
    logic [wkst_pkg::WD_W-1:0]     wd_mar;
    logic [wkst_pkg::WD_W-1:0]     wd_oct;
    logic [wkst_pkg::DAY_W-1:0]    dst_begin;
    logic [wkst_pkg::DAY_W-1:0]    dst_end;
    logic                          summer;

    // reduce sums, find last sundays, decide summer time
    always_comb
    begin
        wd_date   = wkst_pkg::mod7(sum.sum_date);
        wd_mar    = wkst_pkg::mod7(sum.sum_mar);
        wd_oct    = wkst_pkg::mod7(sum.sum_oct);
        dst_begin = wkst_pkg::DAY_LAST - wkst_pkg::DAY_W'(wd_mar);
        dst_end   = wkst_pkg::DAY_LAST - wkst_pkg::DAY_W'(wd_oct);
        summer    = ((sum.month > wkst_pkg::MONTH_MAR) && (sum.month < wkst_pkg::MONTH_OCT))
                 || ((sum.month == wkst_pkg::MONTH_MAR) && (sum.day >= dst_begin))
                 || ((sum.month == wkst_pkg::MONTH_OCT) && (sum.day < dst_end));
        if (sum.invalid)
        begin
            data_next.weekday     = '0;
            data_next.summer_time = 1'b0;
        end
        else
        begin
            data_next.weekday     = wd_date;
            data_next.summer_time = summer;
        end
        data_next.date_invalid = sum.invalid;
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid;
        end
    end

    // output data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign info_valid = valid_reg;
    assign info       = data_reg;

endmodule

@@ hw/rtl/weekday_and_eu_summer_time_unit.sv @@
// channel   direction  handshake                 payload
// date      in         date_valid / date_stall   date (year, month, day)
// info      out        info_valid / info_stall   info (weekday, summer time, invalid)
//
// four register stages: year adjust, century multiply, sums, modulo 7 and summer test
// a date passes each stage register in turn; one date per cycle while info_stall is low
// each stage loads when it is empty or the stage after it moves, so bubbles close up
// a stall on info holds the output register and backs up only as far as stages are full
// reset clears the stage valid bits only

module weekday_and_eu_summer_time_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             date_valid,
    output logic             date_stall,
    input  wkst_pkg::date_t  date,
    output logic             info_valid,
    input  logic             info_stall,
    output wkst_pkg::info_t  info
);

    logic            v1;
    logic            v2;
    logic            v3;
    logic            en1;
    logic            en2;
    logic            en3;
    logic            en4;
    wkst_pkg::prep_t prep;
    wkst_pkg::cent_t cent;
    wkst_pkg::sum_t  sum;

    // stage enables, from the output back
    assign en4 = !info_valid || !info_stall;
    assign en3 = !v3 || en4;
    assign en2 = !v2 || en3;
    assign en1 = !v1 || en2;
    assign date_stall = !en1;

    wkst_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en1),
        .valid      (date_valid),
        .date       (date),
        .prep_valid (v1),
        .prep       (prep)
    );

    wkst_century u_century (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en2),
        .valid      (v1),
        .prep       (prep),
        .cent_valid (v2),
        .cent       (cent)
    );

    wkst_sum u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en3),
        .valid      (v2),
        .cent       (cent),
        .sum_valid  (v3),
        .sum        (sum)
    );

    wkst_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en4),
        .valid      (v3),
        .sum        (sum),
        .info_valid (info_valid),
        .info       (info)
    );

    // an empty first stage never stalls the input
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !v1 |-> !date_stall)
        else $error("input stalled with empty first stage");

    // invalid dates give cleared result fields
    a_invalid_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (info_valid && info.date_invalid) |-> (info.weekday == '0 && !info.summer_time))
        else $error("invalid date with nonzero result");

    // weekday is always a real day
    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        info_valid |-> (info.weekday != 3'd7))
        else $error("weekday out of range");

    // a date taken while info_stall stays low shows up as a valid result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (date_valid && !date_stall && !info_stall) ##1 !info_stall ##1 !info_stall
            ##1 !info_stall |=> info_valid)
        else $error("result missing after four cycles");

endmodule
